@@ rtl/core/sobel_pkg.sv @@
// ----------------------------------------------------------------------------
// Sobel edge package
// Shared widths, register indexes and controller command types.
// ----------------------------------------------------------------------------
package sobel_pkg;
    localparam int DefMaxWidth  = 1024;
    localparam int DefMaxHeight = 4096;
    localparam int PixW   = 8;
    localparam int MagW   = 11;
    localparam int SumW   = 21;
    localparam int CfgW   = 13;
    localparam int IdxW   = 2;

    localparam logic [IdxW-1:0] RegWidth     = 2'd0;
    localparam logic [IdxW-1:0] RegHeight    = 2'd1;
    localparam logic [IdxW-1:0] RegThreshold = 2'd2;

    typedef struct packed {
        logic take;
        logic sqrt_start;
        logic sqrt_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic interior;
        logic sqrt_done;
    } t_status;
endpackage

@@ rtl/core/sobel_datapath.sv @@
// ----------------------------------------------------------------------------
// Sobel edge datapath
// Line stores, window, kernels, bit-serial square root and threshold.
// ----------------------------------------------------------------------------
module sobel_datapath import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_HEIGHT = DefMaxHeight
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data,
    input  logic [PixW-1:0] i_pixel,
    input  t_cmd            i_cmd,
    output t_status         o_status,
    output logic [MagW-1:0] o_edge_value,
    output logic            o_last_of_frame
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_HEIGHT + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [MagW-1:0] r_thr;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [PixW-1:0] r_top_mem [MAX_WIDTH];
    logic [PixW-1:0] r_mid_mem [MAX_WIDTH];
    logic [PixW-1:0] r_win [6];
    logic [PixW-1:0] r_top, r_mid, r_p;
    logic r_rd;
    logic [XW-1:0] r_xp;
    logic [YW-1:0] r_yp;
    logic r_lastp;
    logic is_last;

    logic [WW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    always_comb begin
        if (r_width < 11'd3) w_eff = WW'(3);
        else if ({1'b0, r_width} > 12'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(r_width);
        if (r_height < 13'd3) h_eff = DW'(3);
        else if (18'(r_height) > 18'(MAX_HEIGHT)) h_eff = DW'(MAX_HEIGHT);
        else h_eff = DW'(r_height);
    end

    // Stage one: read the line stores at the current column.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_top <= r_top_mem[r_x];
            r_mid <= r_mid_mem[r_x];
            r_p   <= i_pixel;
        end
        if (r_rd) begin
            r_top_mem[r_xp] <= r_mid;
            r_mid_mem[r_xp] <= r_p;
        end
    end

    assign is_last = (WW'(r_x) == w_eff - WW'(1)) && (DW'(r_y) == h_eff - DW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd640;
            r_height <= 13'd480;
            r_thr <= '0;
            r_x <= '0;
            r_y <= '0;
            r_rd <= 1'b0;
            for (int i = 0; i < 6; i++) r_win[i] <= '0;
        end else begin
            r_rd <= i_cmd.take;
            if (i_cfg_we && i_cfg_idx == RegWidth) begin
                r_width <= i_cfg_data[10:0];
                r_x <= '0;
                r_y <= '0;
            end else if (i_cfg_we && i_cfg_idx == RegHeight) begin
                r_height <= i_cfg_data;
                r_x <= '0;
                r_y <= '0;
            end else if (i_cfg_we && i_cfg_idx == RegThreshold) begin
                r_thr <= i_cfg_data[MagW-1:0];
            end else if (i_cmd.take) begin
                if (WW'(r_x) + WW'(1) >= w_eff) begin
                    r_x <= '0;
                    if (DW'(r_y) + DW'(1) >= h_eff) r_y <= '0;
                    else r_y <= r_y + YW'(1);
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
            if (r_rd) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_top;
                r_win[2] <= r_win[3];
                r_win[3] <= r_mid;
                r_win[4] <= r_win[5];
                r_win[5] <= r_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_xp <= r_x;
            r_yp <= r_y;
            r_lastp <= is_last;
        end
    end

    assign o_status.interior = r_rd && (r_xp >= XW'(2)) && (r_yp >= YW'(2));

    logic signed [11:0] gx, gy;
    always_comb begin
        gx = (12'(r_top) - 12'(r_win[0])) + ((12'(r_mid) - 12'(r_win[2])) <<< 1)
           + (12'(r_p) - 12'(r_win[4]));
        gy = (12'(r_win[4]) + (12'(r_win[5]) << 1) + 12'(r_p))
           - (12'(r_win[0]) + (12'(r_win[1]) << 1) + 12'(r_top));
    end

    // Bit-serial square root: one result bit per step, two radicand bits per step.
    logic [SumW-1:0] r_rem;
    logic [MagW-1:0] r_root;
    logic [3:0] r_cnt;
    logic r_last_s;
    logic [SumW:0] r_sq;
    logic [SumW+1:0] trial;
    logic [SumW+1:0] rem_sh;
    assign rem_sh = {r_rem, 2'b00} | 23'(r_sq[SumW -: 2]);
    assign trial = 23'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_sq <= {1'b0, SumW'(gx * gx) + SumW'(gy * gy)};
            r_rem <= '0;
            r_root <= '0;
            r_cnt <= 4'd0;
            r_last_s <= r_lastp;
        end else if (i_cmd.sqrt_step) begin
            r_sq <= {r_sq[SumW-2:0], 2'b00};
            r_cnt <= r_cnt + 4'd1;
            if (rem_sh >= trial) begin
                r_rem <= SumW'(rem_sh - trial);
                r_root <= {r_root[MagW-2:0], 1'b1};
            end else begin
                r_rem <= SumW'(rem_sh);
                r_root <= {r_root[MagW-2:0], 1'b0};
            end
        end
    end
    assign o_status.sqrt_done = (r_cnt == 4'd11);

    logic [MagW-1:0] mag;
    assign mag = (r_rem > SumW'(r_root)) ? r_root + MagW'(1) : r_root;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_edge_value <= (mag <= r_thr) ? '0 : mag;
            o_last_of_frame <= r_last_s;
        end
    end
endmodule

@@ rtl/core/sobel_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sobel edge controller
// Sequences pixel intake, root iterations and result handoff.
// ----------------------------------------------------------------------------
module sobel_ctrl import sobel_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output logic    o_stall,
    output logic    o_valid,
    output t_cmd    o_cmd
);
    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRead = 2'd1;
    localparam logic [1:0] StRoot = 2'd2;
    localparam logic [1:0] StOut  = 2'd3;

    logic [1:0] r_state, n_state;
    logic r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd = '0;
        o_stall = 1'b1;
        if (r_valid && !i_stall) n_valid = 1'b0;
        unique case (r_state)
            StIdle: begin
                o_stall = !i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.take = 1'b1;
                    n_state = StRead;
                end
            end
            StRead: begin
                if (i_status.interior) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = StRoot;
                end else begin
                    n_state = StIdle;
                end
            end
            StRoot: begin
                if (i_status.sqrt_done) n_state = StOut;
                else o_cmd.sqrt_step = 1'b1;
            end
            StOut: begin
                if (!n_valid) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = StIdle;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end
    assign o_valid = r_valid;
endmodule

@@ rtl/core/sobel_edge_magnitude_threshold.sv @@
// ----------------------------------------------------------------------------
// Sobel edge magnitude with threshold
// Streams raster pixels through line stores and a 3x3 Sobel window.
// ----------------------------------------------------------------------------
// A border pixel passes only through the intake and read states; an interior pixel then
// runs the eleven steps of the bit-serial square root unit and waits until the result
// register is free. No new pixel is taken before the last one is through.
// Reset is synchronous and active low; line stores are not cleared.
module sobel_edge_magnitude_threshold import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = DefMaxWidth,
    parameter int MAX_HEIGHT = DefMaxHeight
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [PixW-1:0] i_pixel,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [MagW-1:0] o_edge_value,
    output logic            o_last_of_frame
);
    t_cmd cmd;
    t_status status;

    sobel_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_stall, .i_status(status),
        .o_stall, .o_valid, .o_cmd(cmd)
    );

    sobel_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_pixel,
        .i_cmd(cmd), .o_status(status), .o_edge_value, .o_last_of_frame
    );
endmodule

@@ rtl/core/sobel_checker.sv @@
// ----------------------------------------------------------------------------
// Sobel edge port checker
// Port-level properties of the result channel and input handshake.
// ----------------------------------------------------------------------------
module sobel_checker import sobel_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [MagW-1:0] o_edge_value,
    input logic            o_last_of_frame
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_edge_value) && $stable(o_last_of_frame))
        else $error("held");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_edge_value <= 11'd1443) else $error("range");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("gap");
endmodule

bind sobel_edge_magnitude_threshold sobel_checker u_chk (.*);

@@ verif/sobel_edge_magnitude_threshold_checker.sv @@
// ----------------------------------------------------------------------------
// Sobel edge checker
// Watches the pixel, result and register ports, predicts each edge result
// from its own copy of the line stores, window and counters, and compares.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_threshold_checker import sobel_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0] i_cfg_data,
    input  logic            i_valid,
    input  logic            i_in_stall,
    input  logic [PixW-1:0] i_pixel,
    input  logic            i_out_valid,
    input  logic            i_stall,
    input  logic [MagW-1:0] i_edge_value,
    input  logic            i_last_of_frame,
    output int              o_pending,
    output int              o_fails
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MagW-1:0] edge_value;
        logic            last;
    } t_edge_result;

    t_edge_result    edge_fifo[$];
    logic [10:0]     width_reg;
    logic [12:0]     height_reg;
    logic [10:0]     thresh_reg;
    logic [PixW-1:0] rows[2*DefMaxWidth];
    logic [PixW-1:0] win[6];
    int unsigned     col;
    int unsigned     row;

    function automatic int unsigned rounded_root(int unsigned s);
        int unsigned r;
        r = 0;
        for (int b = 10; b >= 0; b--) begin
            if ((r + (1 << b)) * (r + (1 << b)) <= s) begin
                r = r + (1 << b);
            end
        end
        if (s - r * r > r) begin
            r = r + 1;
        end
        return r;
    endfunction

    task automatic predict_edge(input logic [PixW-1:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int          gx;
        int          gy;
        int unsigned mag;
        logic [PixW-1:0] top;
        logic [PixW-1:0] mid;
        t_edge_result res;
        w = (width_reg < 3) ? 3 : (width_reg > DefMaxWidth) ? DefMaxWidth : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > DefMaxHeight) ? DefMaxHeight : height_reg;
        x = col % DefMaxWidth;
        top = rows[x];
        mid = rows[DefMaxWidth + x];
        rows[x] = mid;
        rows[DefMaxWidth + x] = p;
        if (x >= 2 && row >= 2) begin
            gx = (int'(top) - int'(win[0])) + 2 * (int'(mid) - int'(win[2]))
                + (int'(p) - int'(win[4]));
            gy = (int'(win[4]) + 2 * int'(win[5]) + int'(p))
                - (int'(win[0]) + 2 * int'(win[1]) + int'(top));
            mag = rounded_root(gx * gx + gy * gy);
            if (mag <= thresh_reg) begin
                mag = 0;
            end
            res.edge_value = mag[MagW-1:0];
            res.last = (x == w - 1 && row == h - 1);
            edge_fifo.push_back(res);
        end
        win[0] = win[1];
        win[1] = top;
        win[2] = win[3];
        win[3] = mid;
        win[4] = win[5];
        win[5] = p;
        if (x + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = x + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_edge_result want;
        if (!i_rst_n) begin
            edge_fifo.delete();
            width_reg = 640;
            height_reg = 480;
            thresh_reg = 0;
            for (int k = 0; k < 6; k++) begin
                win[k] = '0;
            end
            col = 0;
            row = 0;
            o_fails = 0;
        end else begin
            if (i_out_valid && !i_stall) begin
                if (edge_fifo.size() == 0) begin
                    $display("%0t: unexpected result edge=%0d last=%0b", $time,
                        i_edge_value, i_last_of_frame);
                    o_fails = o_fails + 1;
                end else begin
                    want = edge_fifo.pop_front();
                    if (want.edge_value !== i_edge_value || want.last !== i_last_of_frame) begin
                        $display("%0t: expected edge=%0d last=%0b, got edge=%0d last=%0b",
                            $time, want.edge_value, want.last, i_edge_value,
                            i_last_of_frame);
                        o_fails = o_fails + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegWidth: begin
                        width_reg = i_cfg_data[10:0];
                        col = 0;
                        row = 0;
                    end
                    RegHeight: begin
                        height_reg = i_cfg_data[12:0];
                        col = 0;
                        row = 0;
                    end
                    RegThreshold: begin
                        thresh_reg = i_cfg_data[10:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_valid && !i_in_stall) begin
                predict_edge(i_pixel);
            end
        end
        o_pending = edge_fifo.size();
    end

    initial begin
        o_pending = 0;
        o_fails = 0;
    end
endmodule

@@ verif/sobel_edge_magnitude_threshold_test.sv @@
// ----------------------------------------------------------------------------
// Sobel edge testbench
// Streams directed and random frames under several geometries, thresholds
// and handshake idling patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_threshold_test import sobel_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [IdxW-1:0] i_cfg_idx = RegWidth;
    logic [CfgW-1:0] i_cfg_data = '0;
    logic            i_valid = 1'b0;
    logic            o_stall;
    logic [PixW-1:0] i_pixel = '0;
    logic            o_valid;
    logic            i_stall = 1'b0;
    logic [MagW-1:0] o_edge_value;
    logic            o_last_of_frame;
    int              pending;
    int              fails;
    int              send_pct = 0;
    int              stall_pct = 0;
    int              hold_token = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    int              quiet_cycles = 0;

    sobel_edge_magnitude_threshold i_dut (.*);

    sobel_edge_magnitude_threshold_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_pixel(i_pixel), .i_out_valid(o_valid), .i_stall(i_stall),
        .i_edge_value(o_edge_value), .i_last_of_frame(o_last_of_frame),
        .o_pending(pending), .o_fails(fails)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = 300;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 8000) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [PixW-1:0] p);
        while ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[CfgW-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int count, input bit extremes);
        for (int k = 0; k < count; k++) begin
            send_pixel(extremes ? ($urandom_range(1) ? 8'd255 : 8'd0)
                : PixW'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [PixW-1:0] pattern[20];
        pattern = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255,
            8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(RegWidth, 5);
        write_reg(RegHeight, 4);
        write_reg(RegThreshold, 0);
        foreach (pattern[k]) begin
            send_pixel(pattern[k]);
        end
        drain();
        write_reg(RegWidth, 0);
        write_reg(RegHeight, 2);
        send_random(9, 1'b1);
        drain();
        write_reg(RegWidth, 4);
        write_reg(RegHeight, 3);
        write_reg(RegThreshold, 2047);
        send_random(12, 1'b1);
        drain();
        write_reg(RegThreshold, 0);
        write_reg(RegWidth, 2047);
        write_reg(RegHeight, 3);
        send_random(DefMaxWidth + 8, 1'b0);
        drain();
        write_reg(RegWidth, 3);
        write_reg(RegHeight, 8191);
        send_random(60, 1'b0);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 56; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 56; end
                default: begin send_pct = 34; stall_pct = 34; end
            endcase
            if (ph % 2 == 0) begin
                write_reg(RegWidth, $urandom_range(3, 10));
                write_reg(RegHeight, $urandom_range(3, 6));
            end
            write_reg(RegThreshold, (ph % 3 == 0) ? 0 : $urandom_range(600));
            if (ph == 4) begin
                hold_token = hold_token + 1;
            end
            send_random(50, $urandom_range(3) == 0);
            drain();
        end

        repeat (30) @(negedge i_clk);
        if (fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

@@ sobel_edge_magnitude_threshold.f @@
rtl/core/sobel_pkg.sv
rtl/core/sobel_datapath.sv
rtl/core/sobel_ctrl.sv
rtl/core/sobel_edge_magnitude_threshold.sv
rtl/core/sobel_checker.sv
verif/sobel_edge_magnitude_threshold_checker.sv
verif/sobel_edge_magnitude_threshold_test.sv
